/* hdl/imu_frame_crc_deframer_core_macros.svh */
// assertion macros for the imu frame deframer checker
// no dependencies
`ifndef IMU_FRAME_CRC_DEFRAMER_CORE_MACROS_SVH
`define IMU_FRAME_CRC_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication
`define DFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu deframer assertion failed");

// next-cycle implication
`define DFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu deframer assertion failed");

`endif

/* hdl/imu_dfr_pkg.sv */
// shared types and constants of the imu frame deframer
// no dependencies
package imu_dfr_pkg;

    localparam logic [5:0] FRAME_LAST  = 6'd49;
    localparam logic [5:0] CRC_FIRST   = 6'd8;
    localparam logic [5:0] CRC_END     = 6'd46;
    localparam logic [5:0] TRAILER_POS = 6'd46;
    localparam int         DIAG_MISMATCH_BIT = 0;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam int         REC_BYTES   = 46;

    typedef enum logic [3:0] {
        FC_TIMESTAMP = 4'd0,
        FC_DIAG      = 4'd1,
        FC_GYRO_X    = 4'd2,
        FC_GYRO_Y    = 4'd3,
        FC_GYRO_Z    = 4'd4,
        FC_ACCEL_X   = 4'd5,
        FC_ACCEL_Y   = 4'd6,
        FC_ACCEL_Z   = 4'd7,
        FC_TEMP      = 4'd8,
        FC_COUNTER   = 4'd9,
        FC_MCU_TIME  = 4'd10,
        FC_ENC_1     = 4'd11,
        FC_ENC_2     = 4'd12,
        FC_FAILS     = 4'd13,
        FC_FAIL_FLAG = 4'd14
    } field_code_t;

    // one completed frame as handed from front to back
    typedef struct packed {
        logic [REC_BYTES-1:0][7:0] bytes;
        logic                      crc_ok;
        logic [63:0]               fails;
    } frame_rec_t;

endpackage

/* hdl/imu_dfr_front.sv */
// front end: byte intake, frame buffer, crc-32 and failure count
// depends on imu_dfr_pkg
module imu_dfr_front #(
    parameter int FAIL_COUNT_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic                    frame_start,
    output logic                    push,
    output imu_dfr_pkg::frame_rec_t rec
);
    import imu_dfr_pkg::*;

    logic [5:0]                 pos_reg, pos_next, pos_eff;
    logic [31:0]                crc_reg, crc_next, crc_base, crc_upd;
    logic [FAIL_COUNT_BITS-1:0] fails_reg, fails_next;
    logic [7:0]                 buf_mem [0:48];
    logic                       last_byte, in_crc, crc_ok;
    logic [31:0]                trailer;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    always_comb
    begin
        pos_eff   = frame_start ? 6'd0 : pos_reg;
        crc_base  = frame_start ? CRC_INIT : crc_reg;
        crc_upd   = crc_byte(crc_base, data_byte);
        in_crc    = (pos_eff >= CRC_FIRST) && (pos_eff < CRC_END);
        last_byte = (pos_eff == FRAME_LAST);
        trailer   = {data_byte, buf_mem[TRAILER_POS + 6'd2], buf_mem[TRAILER_POS + 6'd1],
                     buf_mem[TRAILER_POS]};
        crc_ok    = ((crc_base ^ CRC_INIT) == trailer);

        pos_next  = pos_reg;
        crc_next  = crc_reg;
        fails_next = fails_reg;
        if (accept)
        begin
            pos_next = last_byte ? 6'd0 : pos_eff + 6'd1;
            crc_next = last_byte ? CRC_INIT : (in_crc ? crc_upd : crc_base);
            if (last_byte && !crc_ok && (fails_reg != {FAIL_COUNT_BITS{1'b1}}))
            begin
                fails_next = fails_reg + 1'b1;
            end
        end

        push = accept && last_byte;
        for (int i = 0; i < REC_BYTES; i++)
        begin
            rec.bytes[i] = buf_mem[i];
        end
        rec.crc_ok = crc_ok;
        rec.fails  = 64'(fails_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            fails_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            fails_reg <= fails_next;
        end
    end

    // frame buffer, every byte of the frame but the last
    always_ff @(posedge clk)
    begin
        if (accept && !last_byte)
        begin
            buf_mem[pos_eff] <= data_byte;
        end
    end

endmodule

/* hdl/imu_dfr_fifo.sv */
// two-entry queue of completed frame records between front and back
// depends on imu_dfr_pkg
module imu_dfr_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  imu_dfr_pkg::frame_rec_t rec_in,
    output logic                    full,
    output logic                    not_empty,
    input  logic                    pop,
    output imu_dfr_pkg::frame_rec_t rec_out
);
    import imu_dfr_pkg::*;

    frame_rec_t  entry_reg [0:1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        not_empty   = (count_reg != 2'd0);
        rec_out     = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= rec_in;
        end
    end

endmodule

/* hdl/imu_dfr_back.sv */
// back end: walks a frame record and emits its 15 field results
// depends on imu_dfr_pkg
module imu_dfr_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rec_valid,
    input  imu_dfr_pkg::frame_rec_t rec,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [63:0]             m_tdata,
    output logic [4:0]              m_tuser,
    output logic                    m_tlast
);
    import imu_dfr_pkg::*;

    field_code_t code_reg, code_next;
    logic        valid_reg, valid_next;
    logic [63:0] value_reg, value_next;
    field_code_t ocode_reg, ocode_next;
    logic        pres_reg, pres_next;
    logic        last_reg, last_next;
    logic        load, sensors_ok;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] field_value(input frame_rec_t r, input field_code_t c);
        logic [63:0] v;
        unique case (c)
            FC_TIMESTAMP: v = r.bytes[7:0];
            FC_DIAG:      v = 64'(r.bytes[9:8]);
            FC_GYRO_X:    v = sx32(r.bytes[13:10]);
            FC_GYRO_Y:    v = sx32(r.bytes[17:14]);
            FC_GYRO_Z:    v = sx32(r.bytes[21:18]);
            FC_ACCEL_X:   v = sx32(r.bytes[25:22]);
            FC_ACCEL_Y:   v = sx32(r.bytes[29:26]);
            FC_ACCEL_Z:   v = sx32(r.bytes[33:30]);
            FC_TEMP:      v = sx16(r.bytes[35:34]);
            FC_COUNTER:   v = 64'(r.bytes[37:36]);
            FC_MCU_TIME:  v = 64'(r.bytes[41:38]);
            FC_ENC_1:     v = sx16(r.bytes[43:42]);
            FC_ENC_2:     v = sx16(r.bytes[45:44]);
            FC_FAILS:     v = r.fails;
            FC_FAIL_FLAG: v = 64'(!r.crc_ok);
            default:      v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        load       = rec_valid && (!valid_reg || m_tready);
        pop        = load && (code_reg == FC_FAIL_FLAG);
        sensors_ok = rec.crc_ok && !rec.bytes[8][DIAG_MISMATCH_BIT];

        code_next  = code_reg;
        valid_next = m_tready ? 1'b0 : valid_reg;
        value_next = value_reg;
        ocode_next = ocode_reg;
        pres_next  = pres_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            value_next = field_value(rec, code_reg);
            ocode_next = code_reg;
            last_next  = (code_reg == FC_FAIL_FLAG);
            code_next  = (code_reg == FC_FAIL_FLAG) ? FC_TIMESTAMP
                                                    : field_code_t'(code_reg + 4'd1);
            unique case (code_reg) inside
                FC_TIMESTAMP, FC_FAILS, FC_FAIL_FLAG:
                    pres_next = 1'b1;
                FC_DIAG, FC_MCU_TIME, FC_ENC_1, FC_ENC_2:
                    pres_next = rec.crc_ok;
                default:
                    pres_next = sensors_ok;
            endcase
        end

        m_tvalid = valid_reg;
        m_tdata  = value_reg;
        m_tuser  = {pres_reg, ocode_reg};
        m_tlast  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg  <= FC_TIMESTAMP;
            valid_reg <= 1'b0;
        end
        else
        begin
            code_reg  <= code_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        ocode_reg <= ocode_next;
        pres_reg  <= pres_next;
        last_reg  <= last_next;
    end

endmodule

/* hdl/imu_frame_crc_deframer_core.sv */
// Byte-serial deframer for a 50-byte little-endian sensor frame checked by reflected CRC-32
// over bytes 8 to 45 against the trailer. It takes one byte per clock cycle while s_tready is high; the
// front end updates the CRC and the frame buffer in the cycle a byte is accepted. On the last
// byte the frame record goes into a two-entry queue and the back end emits 15 field results,
// one per cycle while m_tready is high, through its output register; the first result passes
// through the queue and then the output register. s_tready drops only while two finished
// frames wait in the queue, which only happens when the output side stalls.
// depends on imu_dfr_pkg, imu_dfr_front, imu_dfr_fifo, imu_dfr_back
module imu_frame_crc_deframer_core #(
    parameter int FAIL_COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // field_value
    output logic [4:0]  m_tuser,   // field_code, field_present
    output logic        m_tlast
);
    import imu_dfr_pkg::*;

    frame_rec_t front_rec, head_rec;
    logic       accept, push, pop, q_full, q_valid;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    imu_dfr_front #(
        .FAIL_COUNT_BITS(FAIL_COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .push        (push),
        .rec         (front_rec)
    );

    imu_dfr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rec_in    (front_rec),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (pop),
        .rec_out   (head_rec)
    );

    imu_dfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_valid),
        .rec       (head_rec),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* hdl/imu_dfr_checker.sv */
// port-level checks of the imu frame deframer, bound to the top level
// depends on imu_dfr_pkg and imu_frame_crc_deframer_core_macros.svh
`include "imu_frame_crc_deframer_core_macros.svh"

module imu_dfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);
    import imu_dfr_pkg::*;

    `DFR_ASSERT_IMP(a_last_on_flag, clk, rst_n, m_tvalid, m_tlast == (m_tuser[3:0] == FC_FAIL_FLAG))
    `DFR_ASSERT_IMP(a_always_present, clk, rst_n, m_tvalid && (m_tuser[3:0] == FC_TIMESTAMP || m_tuser[3:0] == FC_FAILS || m_tuser[3:0] == FC_FAIL_FLAG), m_tuser[4])
    `DFR_ASSERT_IMP(a_flag_is_bit, clk, rst_n, m_tvalid && m_tuser[3:0] == FC_FAIL_FLAG, m_tdata[63:1] == 63'd0)
    `DFR_ASSERT_NXT(a_code_order, clk, rst_n, m_tvalid && m_tready && !m_tlast, !m_tvalid || m_tuser[3:0] == $past(m_tuser[3:0]) + 4'd1)
    `DFR_ASSERT_NXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind imu_frame_crc_deframer_core imu_dfr_checker u_checker (.*);

/* dv/tb_imu_frame_crc_deframer_core.sv */
`timescale 1ns / 1ps
// self-checking testbench for imu_frame_crc_deframer_core: streams directed and random
// 50-byte frames, fragments and loose bytes and checks each of the 15 field results against a local frame parser
// depends on imu_dfr_pkg and the deframer rtl
module tb_imu_frame_crc_deframer_core;
    import imu_dfr_pkg::*;

    localparam int FAIL_BITS   = 8;
    localparam int FRAME_BYTES = 50;
    localparam int RAND_ITEMS  = 50;
    localparam int HOLD_AT     = 20;
    localparam int HOLD_CYCLES = 1000;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1200000;
    localparam logic [63:0] FAIL_MAX = {64{1'b1}} >> (64 - FAIL_BITS);

    typedef struct {
        logic [7:0] data;
        logic       start;
        int         gap;
        bit         drain;
    } byte_req_t;

    typedef struct {
        field_code_t code;
        logic [63:0] value;
        logic        present;
        logic        last;
    } field_res_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    byte_req_t  byte_q[$];
    field_res_t field_q[$];

    logic [5:0]  pars_pos  = '0;
    logic [31:0] pars_crc  = CRC_INIT;
    logic [7:0]  pars_bytes [FRAME_BYTES];
    logic [63:0] pars_fails = '0;

    logic [7:0]  frm [FRAME_BYTES];

    int n_err, n_bytes, n_frames, n_bad_crc, n_fields, n_queued, cycles;
    int gap_left, hold_left, stall_left;
    bit long_hold_done;

    imu_frame_crc_deframer_core #(
        .FAIL_COUNT_BITS(FAIL_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: no completion after %0d cycles", $time, cycles);
            $display("imu_frame_crc_deframer_core test failed");
            $finish;
        end
    end

    function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [63:0] pars_le(int first, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v[8*i +: 8] = pars_bytes[first + i];
        return v;
    endfunction

    function automatic logic [63:0] sext(logic [63:0] v, int bits);
        logic [63:0] m;
        m = 64'd1 << (bits - 1);
        v = v & ((m << 1) - 64'd1);
        return (v ^ m) - m;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    task automatic push_field(field_code_t code, logic [63:0] value, logic present);
        field_q.push_back('{code, value, present, code == FC_FAIL_FLAG});
    endtask

    task automatic parse_byte(logic [7:0] b, logic start);
        logic [63:0] trailer;
        logic [63:0] diag;
        logic        ok;
        logic        sensors;
        if (start)
        begin
            pars_pos = '0;
            pars_crc = CRC_INIT;
        end
        pars_bytes[pars_pos] = b;
        if (pars_pos >= CRC_FIRST && pars_pos < CRC_END)
            pars_crc = crc_next(pars_crc, b);
        if (pars_pos != FRAME_LAST)
            pars_pos = pars_pos + 6'd1;
        else
        begin
            trailer = pars_le(TRAILER_POS, 4);
            ok = (~pars_crc == trailer[31:0]);
            if (!ok)
            begin
                n_bad_crc++;
                if (pars_fails < FAIL_MAX)
                    pars_fails = pars_fails + 64'd1;
            end
            diag = pars_le(CRC_FIRST, 2);
            sensors = ok && !diag[DIAG_MISMATCH_BIT];
            push_field(FC_TIMESTAMP, pars_le(0, 8), 1'b1);
            push_field(FC_DIAG, diag, ok);
            for (int k = 0; k < 6; k++)
                push_field(field_code_t'(FC_GYRO_X + k), sext(pars_le(10 + 4 * k, 4), 32),
                           sensors);
            push_field(FC_TEMP, sext(pars_le(34, 2), 16), sensors);
            push_field(FC_COUNTER, pars_le(36, 2), sensors);
            push_field(FC_MCU_TIME, pars_le(38, 4), ok);
            push_field(FC_ENC_1, sext(pars_le(42, 2), 16), ok);
            push_field(FC_ENC_2, sext(pars_le(44, 2), 16), ok);
            push_field(FC_FAILS, pars_fails, 1'b1);
            push_field(FC_FAIL_FLAG, {63'd0, !ok}, 1'b1);
            pars_pos = '0;
            pars_crc = CRC_INIT;
            n_frames++;
        end
    endtask

    task automatic check_field();
        field_res_t want;
        if (field_q.size() == 0)
        begin
            n_err++;
            $display("%0t: expected no result, got code %0d value %h present %b last %b",
                     $time, m_tuser[3:0], m_tdata, m_tuser[4], m_tlast);
        end
        else
        begin
            want = field_q.pop_front();
            n_fields++;
            if (m_tuser[3:0] !== want.code || m_tdata !== want.value ||
                m_tuser[4] !== want.present || m_tlast !== want.last)
            begin
                n_err++;
                $display("%0t: expected code %0d value %h present %b last %b", $time,
                         want.code, want.value, want.present, want.last);
                $display("%0t:      got code %0d value %h present %b last %b", $time,
                         m_tuser[3:0], m_tdata, m_tuser[4], m_tlast);
            end
        end
    endtask

    // byte request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tuser);
                n_bytes++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (byte_q.size() == 0)
                    s_tvalid <= 1'b0;
                else if (byte_q[0].drain)
                begin
                    s_tvalid <= 1'b0;
                    if (field_q.size() == 0)
                        byte_q.delete(0);
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_q[0].data;
                    s_tuser  <= byte_q[0].start;
                    gap_left <= byte_q[0].gap;
                    byte_q.delete(0);
                end
            end
        end
    end

    // result monitor and backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_field();
            if (hold_left != 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!long_hold_done && n_fields >= HOLD_AT)
            begin
                m_tready       <= 1'b0;
                hold_left      <= HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (((n_fields / 60) % 3) != 1 && $urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    task automatic put_byte(logic [7:0] d, logic st, bit calm);
        byte_q.push_back('{d, st, calm ? 0 : pick_gap(), 1'b0});
        n_queued++;
    endtask

    task automatic put_drain();
        byte_q.push_back('{8'd0, 1'b0, 0, 1'b1});
    endtask

    task automatic set_le(int first, int n, logic [63:0] v);
        for (int i = 0; i < n; i++)
            frm[first + i] = v[8*i +: 8];
    endtask

    task automatic fill_frame(logic [7:0] b);
        for (int i = 0; i < FRAME_BYTES; i++)
            frm[i] = b;
    endtask

    task automatic shape_frame_body();
        logic [63:0] pick;
        for (int i = 0; i < FRAME_BYTES; i++)
            frm[i] = 8'($urandom);
        for (int k = 0; k < 6; k++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pick = 64'h8000_0000;
                    1: pick = 64'h7FFF_FFFF;
                    2: pick = 64'h0;
                    default: pick = 64'hFFFF_FFFF;
                endcase
                set_le(10 + 4 * k, 4, pick);
            end
        end
        // mostly sensor-valid diag
        if ($urandom_range(0, 9) < 7)
            frm[CRC_FIRST][DIAG_MISMATCH_BIT] = 1'b0;
    endtask

    task automatic queue_frame(bit good, bit with_start, bit calm);
        logic [31:0] c;
        int          flip;
        c = CRC_INIT;
        for (int i = CRC_FIRST; i < CRC_END; i++)
            c = crc_next(c, frm[i]);
        c = ~c;
        if (!good)
        begin
            flip = $urandom_range(0, 31);
            c[flip] = ~c[flip];
        end
        set_le(TRAILER_POS, 4, {32'd0, c});
        for (int i = 0; i < FRAME_BYTES; i++)
            put_byte(frm[i], with_start && i == 0, calm);
    endtask

    initial
    begin
        int  r;
        int  frag;
        int  base;
        bit  aligned;
        bit  calm;

        // directed: extremes, restarts, back-to-back frames
        fill_frame(8'h00);
        queue_frame(1'b1, 1'b1, 1'b1);
        fill_frame(8'h00);
        set_le(0, 8, 64'h8000_0000_0000_0000);
        for (int k = 0; k < 6; k++)
            set_le(10 + 4 * k, 4, 64'h8000_0000);
        set_le(34, 2, 64'h8000);
        set_le(36, 2, 64'hFFFF);
        set_le(38, 4, 64'hFFFF_FFFF);
        set_le(42, 2, 64'h8000);
        set_le(44, 2, 64'h8000);
        queue_frame(1'b1, 1'b1, 1'b0);
        fill_frame(8'hFF);
        set_le(CRC_FIRST, 2, 64'hFFFE);
        for (int k = 0; k < 6; k++)
            set_le(10 + 4 * k, 4, 64'h7FFF_FFFF);
        set_le(34, 2, 64'h7FFF);
        set_le(36, 2, 64'h0);
        set_le(38, 4, 64'h0);
        set_le(42, 2, 64'h7FFF);
        set_le(44, 2, 64'h7FFF);
        queue_frame(1'b0, 1'b0, 1'b0);
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            put_byte(8'($urandom), 1'b0, 1'b1);
        shape_frame_body();
        queue_frame(1'b1, 1'b1, 1'b1);
        shape_frame_body();
        queue_frame(1'b0, 1'b0, 1'b0);
        put_drain();

        // random: mostly well-formed frames, some fragments and loose bytes
        base = n_queued;
        aligned = 1'b1;
        while (n_queued - base < RAND_ITEMS)
        begin
            r = $urandom_range(0, 99);
            calm = ($urandom_range(0, 3) == 0);
            if (r < 75)
            begin
                shape_frame_body();
                queue_frame($urandom_range(0, 4) != 0,
                            !aligned || $urandom_range(0, 2) != 0, calm);
                aligned = 1'b1;
            end
            else if (r < 88)
            begin
                frag = $urandom_range(1, FRAME_BYTES - 1);
                for (int i = 0; i < frag; i++)
                    put_byte(8'($urandom), i == 0 && $urandom_range(0, 1) != 0, calm);
                aligned = 1'b0;
            end
            else
            begin
                frag = $urandom_range(1, 6);
                for (int i = 0; i < frag; i++)
                    put_byte(8'($urandom), $urandom_range(0, 1) != 0, calm);
                aligned = 1'b0;
            end
        end
        put_drain();

        while (byte_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (field_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bytes, %0d complete frames, %0d crc failures,", n_bytes,
                 n_frames, n_bad_crc);
        $display("%0d field results checked, failure count ended at %0d", n_fields,
                 pars_fails);
        if (n_err == 0 && field_q.size() == 0)
            $display("imu_frame_crc_deframer_core test passed");
        else
            $display("imu_frame_crc_deframer_core test failed");
        $finish;
    end

endmodule
